/* rtl/lhf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared types and constants for the link health failover block.
// ----------------------------------------------------------------------------
package lhf_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOWN_FAIL_COUNT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UP_FAIL_COUNT   = 1'd1;

   localparam int THRESH_WIDTH = 4;
   localparam logic [THRESH_WIDTH-1:0] DOWN_FAIL_RESET = 4'd3;
   localparam logic [THRESH_WIDTH-1:0] UP_FAIL_RESET   = 4'd2;

   typedef struct packed {
      logic [2:0] port_index;
      logic       success;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] active_port;
      logic       switched;
      logic [7:0] port_up_mask;
      logic [3:0] window_successes;
      logic       status_changed;
   } rsp_payload_type;

   // per-port view of the update in flight
   typedef struct packed {
      logic [3:0] successes;
      logic       up_next;
      logic       changed;
   } port_status_type;

endpackage

/* rtl/lhf_port_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_port_window
// Outcome window, ring pointer, success count and up/down status of one port.
// ----------------------------------------------------------------------------
module lhf_port_window import lhf_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update_en,
   input  logic                    success,
   input  logic [THRESH_WIDTH-1:0] down_fail_count,
   input  logic [THRESH_WIDTH-1:0] up_fail_count,
   output port_status_type         status
);

   localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW    = $clog2(WINDOW + 1);
   localparam int CMP_W = (CW > THRESH_WIDTH) ? CW : THRESH_WIDTH;

   logic [WINDOW-1:0] window_ff, window_in;
   logic [PW-1:0]     pointer_ff, pointer_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              up_ff, up_in;
   logic [CW-1:0]     fails;
   logic              go_down, go_up;

   always_comb begin
      window_in             = window_ff;
      window_in[pointer_ff] = success;
      count_in   = count_ff - CW'(window_ff[pointer_ff]) + CW'(success);
      pointer_in = (pointer_ff == PW'(WINDOW - 1)) ? '0 : pointer_ff + PW'(1);
      fails      = CW'(WINDOW) - count_in;
      go_down    = up_ff && (CMP_W'(fails) >= CMP_W'(down_fail_count));
      go_up      = !up_ff && (CMP_W'(fails) <= CMP_W'(up_fail_count));
      up_in      = go_down ? 1'b0 : (go_up ? 1'b1 : up_ff);

      status.successes = 4'(count_in);
      status.up_next   = update_en ? up_in : up_ff;
      status.changed   = update_en && (go_down || go_up);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '1;
         pointer_ff <= '0;
         count_ff   <= CW'(WINDOW);
         up_ff      <= 1'b1;
      end else if (update_en) begin
         window_ff  <= window_in;
         pointer_ff <= pointer_in;
         count_ff   <= count_in;
         up_ff      <= up_in;
      end
   end

endmodule

/* rtl/lhf_active_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_active_select
// Priority pick of the lowest-numbered up port, last port when none is up.
// ----------------------------------------------------------------------------
module lhf_active_select import lhf_pkg::*; #(
   parameter int NUM_PORTS = 3
) (
   input  logic [NUM_PORTS-1:0] up_mask,
   output logic [2:0]           active_port
);

   always_comb begin
      active_port = 3'(NUM_PORTS - 1);
      for (int i = NUM_PORTS - 1; i >= 0; i--) begin
         if (up_mask[i]) begin
            active_port = 3'(i);
         end
      end
   end

endmodule

/* rtl/link_health_failover_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_health_failover_core
// Sliding-window probe monitor per link port with priority failover.
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per probe outcome (port_index, success), valid/stall
//   rsp channel: one beat per probe with active port, switch flag, up mask,
//     window success count of the probed port and its status change flag
//   csr port: write-only thresholds, index 0 down_fail_count, 1 up_fail_count;
//     write only while no probe is in flight
// timing
//   a probe sits in the input register, then its update and result are
//   computed in one pass and land in the result register once that register
//   is empty or being drained; one beat per cycle sustained while
//   rsp_stall stays low
//   per-port state updates as the beat moves into the result register, so the
//   next probe for the same port sees it with no bubble
// reset
//   all windows full of successes, every port up, active port 0, thresholds
//   back to 3 and 2, both pipeline registers empty
// stall
//   a stalled rsp beat holds; the input register still takes one more beat,
//   then req_stall rises until the result register frees up
// probes for port_index at or above NUM_PORTS change no state
// ----------------------------------------------------------------------------
module link_health_failover_core import lhf_pkg::*; #(
   parameter int NUM_PORTS = 3,
   parameter int WINDOW    = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [THRESH_WIDTH-1:0]    csr_write_data
);

   // threshold registers
   logic [THRESH_WIDTH-1:0] down_fail_ff;
   logic [THRESH_WIDTH-1:0] up_fail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         down_fail_ff <= DOWN_FAIL_RESET;
         up_fail_ff   <= UP_FAIL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DOWN_FAIL_COUNT: down_fail_ff <= csr_write_data;
            CSR_UP_FAIL_COUNT:   up_fail_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   logic            in_valid_ff;
   req_payload_type in_beat_ff;
   logic            req_accept;
   logic            advance;

   // beat moves on when the result register is empty or being drained
   assign advance    = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_beat_ff <= req_payload;
      end
   end

   // per-port monitors
   logic                in_range;
   logic [NUM_PORTS-1:0] hit;
   logic [NUM_PORTS-1:0] up_next;
   port_status_type     port_status [NUM_PORTS];

   assign in_range = {1'b0, in_beat_ff.port_index} < 4'(NUM_PORTS);

   for (genvar p = 0; p < NUM_PORTS; p++) begin : g_port
      assign hit[p] = advance && (in_beat_ff.port_index == 3'(p));

      lhf_port_window #(
         .WINDOW(WINDOW)
      ) u_window (
         .clock          (clock),
         .reset          (reset),
         .update_en      (hit[p]),
         .success        (in_beat_ff.success),
         .down_fail_count(down_fail_ff),
         .up_fail_count  (up_fail_ff),
         .status         (port_status[p])
      );

      assign up_next[p] = port_status[p].up_next;
   end

   // failover pick over the post-update up mask
   logic [2:0] active_port;

   lhf_active_select #(
      .NUM_PORTS(NUM_PORTS)
   ) u_select (
      .up_mask    (up_next),
      .active_port(active_port)
   );

   // result assembly; out-of-range probes report zeros for the port fields
   logic [2:0]      current_port_ff;
   rsp_payload_type rsp_in;

   always_comb begin
      rsp_in.active_port      = active_port;
      rsp_in.switched         = active_port != current_port_ff;
      rsp_in.port_up_mask     = 8'(up_next);
      rsp_in.window_successes = '0;
      rsp_in.status_changed   = 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
         if (in_range && (in_beat_ff.port_index == 3'(i))) begin
            rsp_in.window_successes = port_status[i].successes;
            rsp_in.status_changed   = port_status[i].changed;
         end
      end
   end

   // result register and active port
   logic            rsp_valid_ff;
   rsp_payload_type rsp_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         current_port_ff <= '0;
      end else if (advance) begin
         rsp_valid_ff    <= 1'b1;
         current_port_ff <= active_port;
      end else if (!rsp_stall) begin
         rsp_valid_ff    <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_beat_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_beat_ff;

endmodule

/* tb/lhf_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_tb_pkg
// Link state tracker for the failover testbench: mirrors per-port probe
// windows and thresholds, queues the status beat each probe should produce
// and compares returned beats against it.
// ----------------------------------------------------------------------------
package lhf_tb_pkg;
   import lhf_pkg::*;

   localparam int LINK_PORTS   = 3;
   localparam int WINDOW_DEPTH = 10;

   class link_state_tracker;
      logic [WINDOW_DEPTH-1:0] history [LINK_PORTS];
      int                      ring_slot [LINK_PORTS];
      int                      good_count [LINK_PORTS];
      bit                      link_up [LINK_PORTS];
      logic [2:0]              active;
      logic [THRESH_WIDTH-1:0] down_limit;
      logic [THRESH_WIDTH-1:0] up_limit;
      rsp_payload_type         expected_status [$];
      int                      mismatches;
      int                      probes_seen;
      int                      beats_checked;
      int                      failovers;
      int                      status_flips;

      function new();
         for (int i = 0; i < LINK_PORTS; i++) begin
            history[i]    = '1;
            ring_slot[i]  = 0;
            good_count[i] = WINDOW_DEPTH;
            link_up[i]    = 1'b1;
         end
         active     = '0;
         down_limit = DOWN_FAIL_RESET;
         up_limit   = UP_FAIL_RESET;
      endfunction

      function void set_threshold(logic [CSR_INDEX_WIDTH-1:0] index,
                                  logic [THRESH_WIDTH-1:0] data);
         if (index == CSR_DOWN_FAIL_COUNT) begin
            down_limit = data;
         end else begin
            up_limit = data;
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      // work out the status beat for one accepted probe
      function void note_probe(req_payload_type beat);
         rsp_payload_type want;
         logic [2:0]      prev;
         int              p;
         int              slot;
         int              fails;
         logic [7:0]      mask;
         want = '0;
         prev = active;
         probes_seen++;
         if (beat.port_index < LINK_PORTS) begin
            p    = beat.port_index;
            slot = ring_slot[p];
            if (history[p][slot]) good_count[p]--;
            history[p][slot] = beat.success;
            if (beat.success) good_count[p]++;
            ring_slot[p] = (slot + 1 >= WINDOW_DEPTH) ? 0 : slot + 1;
            fails = WINDOW_DEPTH - good_count[p];
            want.window_successes = 4'(good_count[p]);
            // only the test that matches the current status applies
            if (link_up[p] && fails >= int'(down_limit)) begin
               link_up[p] = 1'b0;
               want.status_changed = 1'b1;
            end else if (!link_up[p] && fails <= int'(up_limit)) begin
               link_up[p] = 1'b1;
               want.status_changed = 1'b1;
            end
         end
         // lowest up port wins, last port when none is up
         active = 3'(LINK_PORTS - 1);
         mask   = '0;
         for (int i = LINK_PORTS - 1; i >= 0; i--) begin
            if (link_up[i]) begin
               active  = 3'(i);
               mask[i] = 1'b1;
            end
         end
         want.active_port  = active;
         want.switched     = (active != prev);
         want.port_up_mask = mask;
         if (want.switched) failovers++;
         if (want.status_changed) status_flips++;
         expected_status.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= 30)
               $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_status(rsp_payload_type got);
         rsp_payload_type want;
         beats_checked++;
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 30)
               $display("%0t: status beat expected none actual %h", $time, got);
            return;
         end
         want = expected_status.pop_front();
         compare_field("active_port", want.active_port, got.active_port);
         compare_field("switched", want.switched, got.switched);
         compare_field("port_up_mask", want.port_up_mask, got.port_up_mask);
         compare_field("window_successes", want.window_successes, got.window_successes);
         compare_field("status_changed", want.status_changed, got.status_changed);
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Probe-driven check of link_health_failover_core: directed probes walk ports
// down, up and across odd thresholds, then phases of random probes with
// per-port failure bias run under varied thresholds and random idle/stall.
// ----------------------------------------------------------------------------
module tb_top;
   import lhf_pkg::*;
   import lhf_tb_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_PROBES  = 64;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_payload_type            req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_payload_type            rsp_payload;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [THRESH_WIDTH-1:0]    csr_write_data;

   link_state_tracker tracker;
   bit                quiet;        // no idling on either side while set
   int                settings_run;
   int                idle_cycles;

   link_health_failover_core #(
      .NUM_PORTS (LINK_PORTS),
      .WINDOW    (WINDOW_DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // sample both channels at the rising edge; the tracker sees every probe
   // beat and every status beat, the watchdog counts edges with no beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_probe(req_payload);
         if (rsp_valid && !rsp_stall) tracker.check_status(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // result side: a random stall ahead of each beat, none when quiet
   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         hold = quiet ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one probe beat; valid only drops when a gap is drawn, so back-to-back
   // beats keep it high with no lower-and-raise in the same step
   task automatic send_probe(input logic [2:0] port, input logic ok);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{port_index: port, success: ok};
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait for every status beat, then let the pipe settle
   task automatic drain_probes();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [CSR_INDEX_WIDTH-1:0] index,
                                  input logic [THRESH_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_threshold(index, data);
   endtask

   task automatic set_thresholds(input logic [THRESH_WIDTH-1:0] down_value,
                                 input logic [THRESH_WIDTH-1:0] up_value);
      drain_probes();
      write_threshold(CSR_DOWN_FAIL_COUNT, down_value);
      write_threshold(CSR_UP_FAIL_COUNT, up_value);
      settings_run++;
   endtask

   initial begin
      int          fail_pct [LINK_PORTS];
      logic [2:0]  port;
      logic        ok;
      logic [3:0]  down_value;
      logic [3:0]  up_value;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_DOWN_FAIL_COUNT;
      csr_write_data   = '0;
      quiet            = 1'b0;
      settings_run     = 1;
      idle_cycles      = 0;
      tracker          = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: take every port down in turn, none left up means
      // the last port stays active; out-of-range ports touch nothing
      repeat (3) send_probe(3'd0, 1'b0);
      send_probe(3'd3, 1'b1);
      send_probe(3'd7, 1'b0);
      repeat (3) send_probe(3'd1, 1'b0);
      repeat (3) send_probe(3'd2, 1'b0);
      send_probe(3'd5, 1'b1);
      send_probe(3'd6, 1'b0);

      // up threshold at the window size brings a down port back at once
      set_thresholds(4'd10, 4'd10);
      send_probe(3'd1, 1'b1);
      send_probe(3'd0, 1'b0);
      send_probe(3'd4, 1'b0);

      // down threshold zero with a high up threshold: every probe toggles
      set_thresholds(4'd0, 4'd15);
      send_probe(3'd2, 1'b1);
      send_probe(3'd0, 1'b1);
      send_probe(3'd0, 1'b0);
      send_probe(3'd1, 1'b0);

      // down threshold above the window never takes a port down
      set_thresholds(4'd15, 4'd0);
      send_probe(3'd0, 1'b0);
      send_probe(3'd1, 1'b1);
      send_probe(3'd2, 1'b0);

      // random phases: each gets its own thresholds and per-port failure bias
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               down_value = 4'd1;
               up_value   = 4'd0;
            end
            1: begin
               down_value = 4'd10;
               up_value   = 4'd10;
            end
            2: begin
               down_value = 4'd0;
               up_value   = 4'd15;
            end
            default: begin
               if ($urandom_range(0, 4) == 0) begin
                  down_value = 4'($urandom_range(0, 15));
                  up_value   = 4'($urandom_range(0, 15));
               end else begin
                  down_value = 4'($urandom_range(2, 8));
                  up_value   = 4'($urandom_range(0, down_value - 1));
               end
            end
         endcase
         set_thresholds(down_value, up_value);
         quiet = (phase % 3 == 1);
         foreach (fail_pct[i]) begin
            case ($urandom_range(0, 3))
               0: fail_pct[i] = 10;
               1: fail_pct[i] = 30;
               2: fail_pct[i] = 50;
               default: fail_pct[i] = 80;
            endcase
         end
         for (int n = 0; n < PHASE_PROBES; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               port = 3'($urandom_range(LINK_PORTS, 7));
               ok   = 1'($urandom_range(0, 1));
            end else begin
               port = 3'($urandom_range(0, LINK_PORTS - 1));
               ok   = ($urandom_range(0, 99) >= fail_pct[port]);
            end
            send_probe(port, ok);
         end
      end

      // end of run: wait for the last status beat, then watch for strays
      quiet = 1'b0;
      drain_probes();
      repeat (5) @(posedge clock);
      $display("%0d probes sent, %0d status beats checked over %0d threshold settings",
               tracker.probes_seen, tracker.beats_checked, settings_run);
      $display("%0d failovers and %0d port status changes predicted",
               tracker.failovers, tracker.status_flips);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* link_health_failover_core.f */
rtl/lhf_pkg.sv
rtl/lhf_port_window.sv
rtl/lhf_active_select.sv
rtl/link_health_failover_core.sv
tb/lhf_tb_pkg.sv
tb/tb_top.sv
